/* design/bzt_pkg.sv */
// Shared constants and types for the cubic Bezier tessellator.
// No dependencies; every other file in design/ refers to it by scoped name.
package bzt_pkg;

  localparam int COORD_W   = 32;                 // signed fixed-point coordinate
  localparam int FRAC      = 16;                 // fraction bits of a coordinate
  localparam int ONE_W     = FRAC + 1;           // t, u, u^2, t^2 (up to 1.0)
  localparam int WGT_W     = FRAC + 2;           // Bernstein weights (up to 3.0)
  localparam int STEPS_W   = 6;
  localparam int MUL_A_W   = COORD_W + 1;
  localparam int MUL_B_W   = WGT_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SHIFT_W   = PROD_W - FRAC;
  localparam int ACC_W     = SHIFT_W + 2;        // sum of four shifted products
  localparam int OP_W      = 5;
  localparam int NUM_PTS   = 4;
  localparam int NUM_AXES  = 3;

  localparam logic [ONE_W-1:0]   ONE       = {1'b1, {FRAC{1'b0}}};
  localparam logic [STEPS_W-1:0] MAX_STEPS = STEPS_W'(63);
  localparam logic [STEPS_W-1:0] STEPS_RST = STEPS_W'(16);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [WGT_W-1:0]          wgt_t;
  typedef logic [ONE_W-1:0]          frac_t;
  typedef logic [STEPS_W-1:0]        steps_t;
  typedef logic [OP_W-1:0]           op_t;

  // travels alongside an operand pair through the multiplier
  typedef struct packed {
    logic valid;
    op_t  op;
  } mul_tag_t;

endpackage

/* design/bzt_if.sv */
// Handshake channels of the tessellator: segment input and line output.
// Depends on bzt_pkg for the coordinate width.
interface bzt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bzt_pkg::COORD_W-1:0]    p0_x, p0_y, p0_z;
  logic signed [bzt_pkg::COORD_W-1:0]    p1_x, p1_y, p1_z;
  logic signed [bzt_pkg::COORD_W-1:0]    p2_x, p2_y, p2_z;
  logic signed [bzt_pkg::COORD_W-1:0]    p3_x, p3_y, p3_z;

  modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
  modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface bzt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bzt_pkg::COORD_W-1:0]    start_x, start_y, start_z;
  logic signed [bzt_pkg::COORD_W-1:0]    end_x, end_y, end_z;
  logic                                  last_line;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  last_line, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  last_line, output ready);
endinterface

/* design/bzt_recip_div.sv */
// Bit-serial restoring divider: ONE / divisor, one quotient bit per cycle.
// Depends on bzt_pkg.
module bzt_recip_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bzt_pkg::steps_t     divisor,
  output logic                done,
  output bzt_pkg::frac_t      quo,
  output bzt_pkg::steps_t     rem
);

  localparam int CNT_W = $clog2(bzt_pkg::ONE_W + 1);

  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [bzt_pkg::STEPS_W:0]  trial;
  logic                       fits;

  always_comb begin
    trial = {rem, quo[bzt_pkg::ONE_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= bzt_pkg::ONE;
        rem  <= '0;
        cnt  <= CNT_W'(bzt_pkg::ONE_W);
        busy <= 1'b1;
      end else if (busy) begin
        // dividend bits shift out of the top while quotient bits enter below
        quo <= {quo[bzt_pkg::ONE_W-2:0], fits};
        rem <= fits ? bzt_pkg::STEPS_W'(trial - {1'b0, divisor})
                    : trial[bzt_pkg::STEPS_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/bzt_mul.sv */
// Shared signed multiplier with registered product and operation tag.
// Depends on bzt_pkg.
module bzt_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  bzt_pkg::mul_tag_t                   tag_in,
  input  logic signed [bzt_pkg::MUL_A_W-1:0]  a,
  input  logic signed [bzt_pkg::MUL_B_W-1:0]  b,
  output bzt_pkg::mul_tag_t                   tag_out,
  output logic signed [bzt_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    prod <= bzt_pkg::PROD_W'(a) * bzt_pkg::PROD_W'(b);
  end

endmodule

/* design/cubic_bezier_tessellator_core.sv */
// Top level of the cubic Bezier tessellator: sequencer, operand selection,
// accumulation and output register. Depends on bzt_pkg, bzt_if, bzt_recip_div, bzt_mul.
//
//  channel        dir  handshake            payload
//  in_seg         in   valid/ready          p0..p3 x/y/z, signed Q16.16
//  out_line       out  valid/ready          start/end x/y/z, last_line
//  cfg_wr_*       in   write enable only    segment_steps (6 bit)
//
// Each sample needs 18 products through the one multiplier (6 for the
// weights, 12 for the coordinates) plus drain and emit; ONE/N is formed once
// per item by the serial divider. Sample t then advances by adding.
// Reset is synchronous; segment_steps returns to 16. A stalled output holds
// the sequencer in its emit or close step; the next segment is taken while
// the last line still waits.
module cubic_bezier_tessellator_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  bzt_pkg::steps_t         cfg_wr_data,
  bzt_in_if.sink                  in_seg,
  bzt_out_if.source               out_line
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_CALC, S_EMIT, S_CLOSE} state_t;

  localparam bzt_pkg::op_t OP_UU    = bzt_pkg::OP_W'(0);   // u*u   -> u2
  localparam bzt_pkg::op_t OP_TT    = bzt_pkg::OP_W'(1);   // t*t   -> t2
  localparam bzt_pkg::op_t OP_U3    = bzt_pkg::OP_W'(2);   // u2*u  -> w0
  localparam bzt_pkg::op_t OP_U2T   = bzt_pkg::OP_W'(3);   // u2*t  -> w1
  localparam bzt_pkg::op_t OP_UT2   = bzt_pkg::OP_W'(4);   // u*t2  -> w2
  localparam bzt_pkg::op_t OP_T3    = bzt_pkg::OP_W'(5);   // t2*t  -> w3
  localparam bzt_pkg::op_t OP_PX0   = bzt_pkg::OP_W'(6);   // first coordinate product
  localparam bzt_pkg::op_t OP_LAST  = bzt_pkg::OP_W'(17);
  localparam bzt_pkg::op_t OP_DRAIN = bzt_pkg::OP_W'(18);

  localparam int NUM_P = bzt_pkg::NUM_PTS * bzt_pkg::NUM_AXES;
  localparam int AXIS_STRIDE = bzt_pkg::NUM_PTS;

  localparam logic signed [bzt_pkg::ACC_W-1:0] CMAX =
    {{(bzt_pkg::ACC_W-bzt_pkg::COORD_W+1){1'b0}}, {(bzt_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [bzt_pkg::ACC_W-1:0] CMIN =
    {{(bzt_pkg::ACC_W-bzt_pkg::COORD_W+1){1'b1}}, {(bzt_pkg::COORD_W-1){1'b0}}};

  function automatic bzt_pkg::coord_t sat_coord(input logic signed [bzt_pkg::ACC_W-1:0] v);
    if (v > CMAX)      return CMAX[bzt_pkg::COORD_W-1:0];
    else if (v < CMIN) return CMIN[bzt_pkg::COORD_W-1:0];
    else               return v[bzt_pkg::COORD_W-1:0];
  endfunction

  state_t                 state;
  bzt_pkg::steps_t        steps_cfg;
  bzt_pkg::steps_t        steps_q;
  bzt_pkg::steps_t        step_idx;
  bzt_pkg::steps_t        r_q;
  bzt_pkg::frac_t         t_q;
  bzt_pkg::frac_t         u2;
  bzt_pkg::frac_t         t2;
  bzt_pkg::wgt_t          wgt [bzt_pkg::NUM_PTS];
  bzt_pkg::op_t           op;
  bzt_pkg::coord_t        pts [NUM_P];               // index = axis*4 + point
  bzt_pkg::coord_t        prev [bzt_pkg::NUM_AXES];
  bzt_pkg::coord_t        pt [bzt_pkg::NUM_AXES];
  logic signed [bzt_pkg::ACC_W-1:0] acc;

  logic                   out_vld;
  bzt_pkg::coord_t        out_start [bzt_pkg::NUM_AXES];
  bzt_pkg::coord_t        out_end [bzt_pkg::NUM_AXES];
  logic                   out_last;

  // combinational
  logic                   accept;
  logic                   slot_free;
  bzt_pkg::steps_t        steps_clamped;
  logic                   div_start;
  logic                   div_done;
  bzt_pkg::frac_t         div_quo;
  bzt_pkg::steps_t        div_rem;
  bzt_pkg::frac_t         u;
  bzt_pkg::op_t           idx_iss;
  bzt_pkg::op_t           idx_wb;
  logic [1:0]             j_wb;
  logic [1:0]             c_wb;
  bzt_pkg::mul_tag_t      iss_tag;
  bzt_pkg::mul_tag_t      wb_tag;
  logic signed [bzt_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bzt_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bzt_pkg::PROD_W-1:0]  prod;
  bzt_pkg::frac_t         prod_frac;
  bzt_pkg::wgt_t          prod_wgt;
  bzt_pkg::wgt_t          prod_wgt3;
  logic signed [bzt_pkg::SHIFT_W-1:0] prod_sh;
  logic signed [bzt_pkg::ACC_W-1:0]   acc_sum;
  logic [bzt_pkg::STEPS_W:0]          r_sum;
  logic                   r_wrap;
  bzt_pkg::steps_t        r_next;
  bzt_pkg::frac_t         t_next;

  assign accept        = in_seg.valid && in_seg.ready;
  assign slot_free     = !out_vld || out_line.ready;
  assign steps_clamped = (steps_cfg > bzt_pkg::MAX_STEPS) ? bzt_pkg::MAX_STEPS : steps_cfg;
  assign div_start     = accept && (steps_clamped != '0);
  assign in_seg.ready  = (state == S_IDLE);

  bzt_recip_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (steps_clamped),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  // operand selection for the shared multiplier
  always_comb begin
    u             = bzt_pkg::ONE - t_q;
    idx_iss       = op - OP_PX0;
    iss_tag.valid = (state == S_CALC) && (op <= OP_LAST);
    iss_tag.op    = op;
    case (op)
      OP_UU: begin
        mul_a = bzt_pkg::MUL_A_W'(u);
        mul_b = bzt_pkg::MUL_B_W'(u);
      end
      OP_TT: begin
        mul_a = bzt_pkg::MUL_A_W'(t_q);
        mul_b = bzt_pkg::MUL_B_W'(t_q);
      end
      OP_U3: begin
        mul_a = bzt_pkg::MUL_A_W'(u2);
        mul_b = bzt_pkg::MUL_B_W'(u);
      end
      OP_U2T: begin
        mul_a = bzt_pkg::MUL_A_W'(u2);
        mul_b = bzt_pkg::MUL_B_W'(t_q);
      end
      OP_UT2: begin
        mul_a = bzt_pkg::MUL_A_W'(u);
        mul_b = bzt_pkg::MUL_B_W'(t2);
      end
      OP_T3: begin
        mul_a = bzt_pkg::MUL_A_W'(t2);
        mul_b = bzt_pkg::MUL_B_W'(t_q);
      end
      default: begin
        mul_a = (idx_iss[3:0] < 4'(NUM_P)) ? bzt_pkg::MUL_A_W'(pts[idx_iss[3:0]]) : '0;
        mul_b = bzt_pkg::MUL_B_W'(wgt[idx_iss[1:0]]);
      end
    endcase
  end

  bzt_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (iss_tag),
    .a       (mul_a),
    .b       (mul_b),
    .tag_out (wb_tag),
    .prod    (prod)
  );

  // product write-back and step advance
  always_comb begin
    idx_wb    = wb_tag.op - OP_PX0;
    j_wb      = idx_wb[1:0];
    c_wb      = idx_wb[3:2];
    prod_frac = prod[bzt_pkg::FRAC +: bzt_pkg::ONE_W];
    prod_wgt  = prod[bzt_pkg::FRAC +: bzt_pkg::WGT_W];
    prod_wgt3 = prod_wgt + (prod_wgt << 1);
    prod_sh   = prod[bzt_pkg::PROD_W-1:bzt_pkg::FRAC];   // floor shift
    acc_sum   = ((j_wb == 2'd0) ? '0 : acc) + bzt_pkg::ACC_W'(prod_sh);

    r_sum  = {1'b0, r_q} + {1'b0, div_rem};
    r_wrap = r_sum >= {1'b0, steps_q};
    r_next = r_wrap ? bzt_pkg::STEPS_W'(r_sum - {1'b0, steps_q})
                    : r_sum[bzt_pkg::STEPS_W-1:0];
    t_next = t_q + div_quo + bzt_pkg::ONE_W'(r_wrap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      steps_cfg <= bzt_pkg::STEPS_RST;
      out_vld   <= 1'b0;
      op        <= OP_UU;
    end else begin
      if (cfg_wr_en) begin
        steps_cfg <= cfg_wr_data;
      end
      if (out_vld && out_line.ready) begin
        out_vld <= 1'b0;
      end

      if (wb_tag.valid) begin
        case (wb_tag.op)
          OP_UU:   u2     <= prod_frac;
          OP_TT:   t2     <= prod_frac;
          OP_U3:   wgt[0] <= prod_wgt;
          OP_U2T:  wgt[1] <= prod_wgt3;
          OP_UT2:  wgt[2] <= prod_wgt3;
          OP_T3:   wgt[3] <= prod_wgt;
          default: begin
            acc <= acc_sum;
            if (j_wb == 2'd3) begin
              pt[c_wb] <= sat_coord(acc_sum);
            end
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            pts[0]  <= in_seg.p0_x;
            pts[1]  <= in_seg.p1_x;
            pts[2]  <= in_seg.p2_x;
            pts[3]  <= in_seg.p3_x;
            pts[4]  <= in_seg.p0_y;
            pts[5]  <= in_seg.p1_y;
            pts[6]  <= in_seg.p2_y;
            pts[7]  <= in_seg.p3_y;
            pts[8]  <= in_seg.p0_z;
            pts[9]  <= in_seg.p1_z;
            pts[10] <= in_seg.p2_z;
            pts[11] <= in_seg.p3_z;
            prev[0] <= in_seg.p0_x;
            prev[1] <= in_seg.p0_y;
            prev[2] <= in_seg.p0_z;
            t_q      <= '0;
            r_q      <= '0;
            step_idx <= '0;
            steps_q  <= steps_clamped;
            state    <= (steps_clamped == '0) ? S_CLOSE : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            op    <= OP_UU;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          op <= op + 1'b1;
          if (op == OP_DRAIN) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_vld   <= 1'b1;
            out_start <= prev;
            out_end   <= pt;
            out_last  <= 1'b0;
            prev      <= pt;
            step_idx  <= step_idx + 1'b1;
            t_q       <= t_next;
            r_q       <= r_next;
            op        <= OP_UU;
            state     <= ((step_idx + 1'b1) == steps_q) ? S_CLOSE : S_CALC;
          end
        end
        S_CLOSE: begin
          if (slot_free) begin
            out_vld    <= 1'b1;
            out_start  <= prev;
            out_end[0] <= pts[3];
            out_end[1] <= pts[3 + AXIS_STRIDE];
            out_end[2] <= pts[3 + 2*AXIS_STRIDE];
            out_last   <= 1'b1;
            prev[0]    <= pts[3];
            prev[1]    <= pts[3 + AXIS_STRIDE];
            prev[2]    <= pts[3 + 2*AXIS_STRIDE];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_line.valid     = out_vld;
  assign out_line.start_x   = out_start[0];
  assign out_line.start_y   = out_start[1];
  assign out_line.start_z   = out_start[2];
  assign out_line.end_x     = out_end[0];
  assign out_line.end_y     = out_end[1];
  assign out_line.end_z     = out_end[2];
  assign out_line.last_line = out_last;

endmodule

/* bench/tb_cubic_bezier_tessellator_core.sv */
// Self-checking bench for cubic_bezier_tessellator_core: segments in, line beats out.
// Bit-exact line prediction and queue scoreboard, random stalls on both channels.
// Depends on bzt_pkg, bzt_if and the design files under design/.
module tb_cubic_bezier_tessellator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 800_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 1500;
  localparam int RANDOM_ITEMS  = 96;

  localparam bzt_pkg::coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam bzt_pkg::coord_t C_MIN = 32'sh8000_0000;

  typedef struct {
    bzt_pkg::coord_t pt [4][3];     // [control point][axis]
  } segment_t;

  typedef struct {
    bzt_pkg::coord_t from [3];
    bzt_pkg::coord_t to   [3];
    logic            last;
  } line_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wr_en;
  bzt_pkg::steps_t cfg_wr_data;

  bzt_in_if  in_seg_if ();
  bzt_out_if out_line_if ();

  cubic_bezier_tessellator_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_seg      (in_seg_if.sink),
    .out_line    (out_line_if.source)
  );

  always #5 clk = ~clk;

  segment_t        pending_segments [$];
  line_t           expected_lines   [$];
  segment_t        seg_offered;
  line_t           line_due;
  bzt_pkg::steps_t model_steps = bzt_pkg::STEPS_RST;

  bit idle_on = 1'b1;
  int src_gap, snk_gap, hold_left;
  int holds_requested, holds_served;
  int errors, segments_accepted, lines_checked, settings_seen;
  int cycle_count;

  function automatic bzt_pkg::coord_t clamp_coord(input longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return bzt_pkg::coord_t'(v);
  endfunction

  // Curve samples at t = floor(i*ONE/n), each weighted product floored, then the closing line.
  task automatic tessellate(input segment_t seg);
    longint one_q, t, u, u2, u3, t2, t3, acc;
    longint w [4];
    bzt_pkg::coord_t prev [3];
    bzt_pkg::coord_t pt [3];
    line_t  ln;
    int unsigned n;
    one_q = longint'(1) << bzt_pkg::FRAC;
    n = (model_steps > bzt_pkg::MAX_STEPS) ? bzt_pkg::MAX_STEPS : model_steps;
    prev = seg.pt[0];
    for (int unsigned i = 0; i < n; i++) begin
      t  = (longint'(i) * one_q) / longint'(n);
      u  = one_q - t;
      u2 = (u * u) >>> bzt_pkg::FRAC;
      u3 = (u2 * u) >>> bzt_pkg::FRAC;
      t2 = (t * t) >>> bzt_pkg::FRAC;
      t3 = (t2 * t) >>> bzt_pkg::FRAC;
      w[0] = u3;
      w[1] = 3 * ((u2 * t) >>> bzt_pkg::FRAC);
      w[2] = 3 * ((u * t2) >>> bzt_pkg::FRAC);
      w[3] = t3;
      for (int a = 0; a < 3; a++) begin
        acc = 0;
        for (int j = 0; j < 4; j++)
          acc += (longint'(seg.pt[j][a]) * w[j]) >>> bzt_pkg::FRAC;
        pt[a] = clamp_coord(acc);
      end
      ln.from = prev;
      ln.to   = pt;
      ln.last = 1'b0;
      expected_lines.push_back(ln);
      prev = pt;
    end
    ln.from = prev;
    ln.to   = seg.pt[3];
    ln.last = 1'b1;
    expected_lines.push_back(ln);
  endtask

  function automatic bzt_pkg::coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return bzt_pkg::coord_t'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      3: return '0;
      default: return bzt_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    for (int j = 0; j < 4; j++)
      for (int a = 0; a < 3; a++)
        s.pt[j][a] = rand_coord();
    return s;
  endfunction

  // same value on every axis of a point
  function automatic segment_t seg_of(input bzt_pkg::coord_t a, input bzt_pkg::coord_t b,
                                      input bzt_pkg::coord_t c, input bzt_pkg::coord_t d);
    segment_t s;
    for (int ax = 0; ax < 3; ax++) begin
      s.pt[0][ax] = a;
      s.pt[1][ax] = b;
      s.pt[2][ax] = c;
      s.pt[3][ax] = d;
    end
    return s;
  endfunction

  task automatic check_coord(input string field, input bzt_pkg::coord_t want_v,
                             input bzt_pkg::coord_t got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
      errors++;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_segments.size() != 0 || in_seg_if.valid || expected_lines.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_steps(input int unsigned n);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bzt_pkg::steps_t'(n);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_steps = bzt_pkg::steps_t'(n);
    settings_seen++;
  endtask

  // segment driver
  always @(posedge clk) begin
    if (rst) begin
      in_seg_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_seg_if.valid && in_seg_if.ready) begin
        tessellate(seg_offered);
        segments_accepted++;
      end
      if (!in_seg_if.valid || in_seg_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_seg_if.valid <= 1'b0;
        end else if (pending_segments.size() > 0) begin
          seg_offered = pending_segments.pop_front();
          in_seg_if.p0_x  <= seg_offered.pt[0][0];
          in_seg_if.p0_y  <= seg_offered.pt[0][1];
          in_seg_if.p0_z  <= seg_offered.pt[0][2];
          in_seg_if.p1_x  <= seg_offered.pt[1][0];
          in_seg_if.p1_y  <= seg_offered.pt[1][1];
          in_seg_if.p1_z  <= seg_offered.pt[1][2];
          in_seg_if.p2_x  <= seg_offered.pt[2][0];
          in_seg_if.p2_y  <= seg_offered.pt[2][1];
          in_seg_if.p2_z  <= seg_offered.pt[2][2];
          in_seg_if.p3_x  <= seg_offered.pt[3][0];
          in_seg_if.p3_y  <= seg_offered.pt[3][1];
          in_seg_if.p3_z  <= seg_offered.pt[3][2];
          in_seg_if.valid <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          in_seg_if.valid <= 1'b0;
        end
      end
    end
  end

  // line sink back-pressure; a requested long hold is counted here
  always @(posedge clk) begin
    if (rst) begin
      out_line_if.ready <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_line_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_line_if.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_line_if.ready <= 1'b0;
    end else begin
      out_line_if.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 4) == 0) snk_gap = $urandom_range(1, 9);
    end
  end

  // line monitor
  always @(posedge clk) begin
    if (!rst && out_line_if.valid && out_line_if.ready) begin
      if (expected_lines.size() == 0) begin
        $error("line beat with nothing expected: start_x %0d end_x %0d last_line %0b",
               out_line_if.start_x, out_line_if.end_x, out_line_if.last_line);
        errors++;
      end else begin
        line_due = expected_lines.pop_front();
        check_coord("start_x", line_due.from[0], out_line_if.start_x);
        check_coord("start_y", line_due.from[1], out_line_if.start_y);
        check_coord("start_z", line_due.from[2], out_line_if.start_z);
        check_coord("end_x",   line_due.to[0],   out_line_if.end_x);
        check_coord("end_y",   line_due.to[1],   out_line_if.end_y);
        check_coord("end_z",   line_due.to[2],   out_line_if.end_z);
        if (out_line_if.last_line !== line_due.last) begin
          $error("last_line mismatch: expected %0b, got %0b",
                 line_due.last, out_line_if.last_line);
          errors++;
        end
        lines_checked++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d lines still expected",
             cycle_count, expected_lines.size());
    $display("cubic_bezier_tessellator_core test failed");
    $finish;
  end

  initial begin
    int unsigned n, batch, sent;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset value of the step count
    pending_segments.push_back(seg_of('0, '0, '0, '0));
    pending_segments.push_back(seg_of(C_MAX, C_MAX, C_MAX, C_MAX));
    pending_segments.push_back(seg_of(C_MIN, C_MIN, C_MIN, C_MIN));
    pending_segments.push_back(seg_of(C_MIN, C_MAX, C_MIN, C_MAX));
    pending_segments.push_back(seg_of(C_MAX, C_MIN, C_MAX, C_MIN));
    pending_segments.push_back(seg_of(32'shAAAA_AAAA, 32'sh5555_5555,
                                      32'shAAAA_AAAA, 32'sh5555_5555));
    pending_segments.push_back(rand_segment());
    pending_segments.push_back(rand_segment());
    wait_idle();

    // zero steps: one closing line straight from P0 to P3
    write_steps(0);
    pending_segments.push_back(seg_of(C_MAX, C_MIN, C_MIN, C_MIN));
    pending_segments.push_back(seg_of(C_MIN, C_MAX, C_MAX, C_MAX));
    pending_segments.push_back(rand_segment());
    wait_idle();

    write_steps(63);
    pending_segments.push_back(seg_of(C_MIN, C_MAX, C_MIN, C_MAX));
    pending_segments.push_back(rand_segment());
    wait_idle();

    write_steps(1);
    pending_segments.push_back(seg_of(C_MAX, C_MAX, C_MAX, C_MAX));
    pending_segments.push_back(rand_segment());
    wait_idle();

    // line sink stalls for a long stretch while segments keep coming
    write_steps(2);
    holds_requested++;
    for (int k = 0; k < 8; k++) pending_segments.push_back(rand_segment());
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 15))
        0:       n = 63;
        1, 2:    n = $urandom_range(9, 62);
        default: n = $urandom_range(0, 8);
      endcase
      batch = (n > 8) ? $urandom_range(2, 4) : $urandom_range(8, 16);
      idle_on = (sent + batch >= RANDOM_ITEMS - 20) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_steps(n);
      for (int unsigned k = 0; k < batch; k++) pending_segments.push_back(rand_segment());
      sent += batch;
      wait_idle();
    end

    $display("%0d segments tessellated into %0d checked lines over %0d step settings,",
             segments_accepted, lines_checked, settings_seen);
    $display("zero and 63 steps, saturating extremes and a %0d-cycle sink stall included",
             LONG_HOLD);
    if (errors == 0 && expected_lines.size() == 0)
      $display("cubic_bezier_tessellator_core test passed");
    else
      $display("cubic_bezier_tessellator_core test failed");
    $finish;
  end

endmodule

/* sim.f */
design/bzt_pkg.sv
design/bzt_if.sv
design/bzt_recip_div.sv
design/bzt_mul.sv
design/cubic_bezier_tessellator_core.sv
bench/tb_cubic_bezier_tessellator_core.sv
